// File: sv/brt_pkg.sv
// Shared types and constants of the beat repeat trigger timer.
`default_nettype none

package brt_pkg;

  localparam int unsigned CFG_W = 15;
  localparam int unsigned DEN_W = 2 * CFG_W;
  localparam int unsigned SAMPLE_W = 16;

  // Seconds per minute times the beat scaling factor.
  localparam int unsigned TICK_FACTOR = 240;

  localparam logic [1:0] REG_TEMPO    = 2'd0;
  localparam logic [1:0] REG_BEATS    = 2'd1;
  localparam logic [1:0] REG_DIVISION = 2'd2;
  localparam logic [1:0] REG_REPEAT   = 2'd3;

  localparam logic [CFG_W-1:0] TEMPO_RST    = 15'd120;
  localparam logic [CFG_W-1:0] BEATS_RST    = 15'd1;
  localparam logic [CFG_W-1:0] DIVISION_RST = 15'd4;
  localparam logic [CFG_W-1:0] REPEAT_RST   = 15'd0;

  localparam logic signed [SAMPLE_W-1:0] LEVEL_POS  = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] LEVEL_NEG  = -16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] LEVEL_ZERO = 16'sd0;

  localparam int unsigned TARGET_RST = 187;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_STEP
  } state_e;

  typedef enum logic [1:0] {
    SGN_ZERO = 2'b00,
    SGN_POS  = 2'b01,
    SGN_NEG  = 2'b11
  } sign_e;

  typedef struct packed {
    logic [CFG_W-1:0] tempo;
    logic [CFG_W-1:0] beats;
    logic [CFG_W-1:0] division;
    logic [CFG_W-1:0] repeats;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_start;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic is_event;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: sv/brt_in_if.sv
// Request channel carrying one trigger sample.
`default_nettype none

interface brt_in_if;
  import brt_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] trig_sample;
  logic                       block_start;

  modport source (output valid, output trig_sample, output block_start, input ready);
  modport sink (input valid, input trig_sample, input block_start, output ready);
endinterface

`default_nettype wire

// File: sv/brt_out_if.sv
// Result channel carrying the output trigger level.
`default_nettype none

interface brt_out_if;
  import brt_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] trigger_out;
  logic                       fired;

  modport source (output valid, output trigger_out, output fired, input ready);
  modport sink (input valid, input trigger_out, input fired, output ready);
endinterface

`default_nettype wire

// File: sv/brt_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module brt_div #(
  parameter int unsigned NUM_W = 34,
  parameter int unsigned DIV_W = 30
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DIV_W-1:0] den_i,
  output logic                  busy_o,
  output logic [NUM_W-1:0]      quo_o
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic             ge;

  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    diff    = shifted - {1'b0, den_i};
    ge      = shifted >= {1'b0, den_i};
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d  = {quo_q[NUM_W-2:0], ge};
      rem_d  = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      cnt_d  = cnt_q - CNT_W'(1);
      busy_d = (cnt_q != CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
endmodule

`default_nettype wire

// File: sv/brt_ctrl.sv
// Sequencing state machine of the beat repeat trigger timer.
`default_nettype none

module brt_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire brt_pkg::stat_t stat_i,
  output brt_pkg::cmd_t       cmd_o,
  output logic                in_ready_o
);
  import brt_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (stat_i.in_valid) state_d = ST_EVAL;
      ST_EVAL:   state_d = stat_i.is_event ? ST_MUL : ST_STEP;
      ST_MUL:    state_d = ST_DSTART;
      ST_DSTART: state_d = ST_DIV;
      ST_DIV:    if (!stat_i.div_busy) state_d = ST_STEP;
      ST_STEP:   if (stat_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = stat_i.in_valid;
      end
      ST_MUL:    cmd_o.mul = 1'b1;
      ST_DSTART: cmd_o.div_start = 1'b1;
      ST_STEP:   cmd_o.step = stat_i.out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

`default_nettype wire

// File: sv/brt_datapath.sv
// Event detection, target computation, tick counting and output register.
`default_nettype none

module brt_datapath #(
  parameter int unsigned TICK_SHIFT  = 5,
  parameter int unsigned SAMPLE_RATE = 48000,
  parameter int unsigned COUNT_WIDTH = 34
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire brt_pkg::cmd_t                     cmd_i,
  input  wire brt_pkg::cfg_t                     cfg_i,
  input  wire logic                              in_valid_i,
  input  wire logic signed [brt_pkg::SAMPLE_W-1:0] in_trigger_i,
  input  wire logic                              in_block_start_i,
  input  wire logic                              out_ready_i,
  output brt_pkg::stat_t                         stat_o,
  output logic                                   out_valid_o,
  output logic signed [brt_pkg::SAMPLE_W-1:0]    out_trigger_o,
  output logic                                   out_fired_o
);
  import brt_pkg::*;

  localparam int unsigned TICK_BASE = (SAMPLE_RATE >> TICK_SHIFT) * TICK_FACTOR;
  localparam int unsigned K_W       = $clog2(TICK_BASE + 1);
  localparam int unsigned NUM_W     = K_W + CFG_W;
  localparam int unsigned MAX_W     = (NUM_W > COUNT_WIDTH) ? NUM_W : COUNT_WIDTH;
  localparam int unsigned PH_W      = (TICK_SHIFT > 0) ? TICK_SHIFT : 1;

  localparam logic [K_W-1:0]   TICK_K      = K_W'(TICK_BASE);
  localparam logic [MAX_W-1:0] COUNT_MAX_X = MAX_W'({COUNT_WIDTH{1'b1}});
  localparam logic [PH_W-1:0]  PHASE_MASK  = PH_W'((1 << TICK_SHIFT) - 1);

  logic signed [SAMPLE_W-1:0] trig_q;
  logic                       bstart_q;
  logic [NUM_W-1:0]           num_q;
  logic [DEN_W-1:0]           den_q;
  logic                       den_zero_q;
  logic [NUM_W-1:0]           quo;
  logic                       div_busy;

  sign_e                      sgn_prev_q, cur_sign;
  sign_e                      out_sign_q, out_sign_d;
  logic [PH_W-1:0]            phase_q, phase_d, phase_cur;
  logic [COUNT_WIDTH-1:0]     count_q, count_d, count_base;
  logic [COUNT_WIDTH-1:0]     target_q, target_base, target_new;
  logic [CFG_W-1:0]           done_q, done_d, done_base;
  logic [CFG_W-1:0]           latched_q, latched_base;
  logic [MAX_W-1:0]           quo_x;
  logic                       is_event;
  logic                       fire;
  logic signed [SAMPLE_W-1:0] level;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_trigger_q;
  logic                       out_fired_q;

  brt_div #(
    .NUM_W (NUM_W),
    .DIV_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  always_comb begin
    if (trig_q == '0) begin
      cur_sign = SGN_ZERO;
    end else if (trig_q[SAMPLE_W-1]) begin
      cur_sign = SGN_NEG;
    end else begin
      cur_sign = SGN_POS;
    end
    is_event = (cur_sign != SGN_ZERO) && (cur_sign != sgn_prev_q);
  end

  always_comb begin
    quo_x      = MAX_W'(quo);
    target_new = (den_zero_q || (quo_x > COUNT_MAX_X)) ? '1 : quo_x[COUNT_WIDTH-1:0];
  end

  // An event restarts the counters before the tick of the same sample is taken.
  always_comb begin
    count_base   = is_event ? '0 : count_q;
    target_base  = is_event ? target_new : target_q;
    done_base    = is_event ? '0 : done_q;
    latched_base = is_event ? cfg_i.repeats : latched_q;
    phase_cur    = bstart_q ? '0 : phase_q;
    count_d      = count_base;
    done_d       = done_base;
    fire         = 1'b0;
    if (phase_cur == '0) begin
      if (count_base >= target_base) begin
        if (latched_base == '0) begin
          count_d = '0;
          fire    = 1'b1;
        end else if (done_base < latched_base) begin
          done_d = done_base + CFG_W'(1);
          if (done_d != latched_base) count_d = '0;
          fire = 1'b1;
        end
      end else begin
        count_d = count_base + COUNT_WIDTH'(1);
      end
    end
    phase_d = (phase_cur + PH_W'(1)) & PHASE_MASK;
    if (fire) begin
      out_sign_d = (out_sign_q == SGN_POS) ? SGN_NEG : SGN_POS;
    end else begin
      out_sign_d = out_sign_q;
    end
    case (out_sign_d)
      SGN_POS: level = LEVEL_POS;
      SGN_NEG: level = LEVEL_NEG;
      default: level = LEVEL_ZERO;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      trig_q   <= in_trigger_i;
      bstart_q <= in_block_start_i;
    end
    if (cmd_i.mul) begin
      num_q      <= TICK_K * cfg_i.beats;
      den_q      <= cfg_i.tempo * cfg_i.division;
      den_zero_q <= (cfg_i.tempo == '0) || (cfg_i.division == '0);
    end
    if (cmd_i.step) begin
      out_trigger_q <= level;
      out_fired_q   <= fire;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sgn_prev_q  <= SGN_ZERO;
      out_sign_q  <= SGN_ZERO;
      phase_q     <= '0;
      count_q     <= '0;
      target_q    <= COUNT_WIDTH'(TARGET_RST);
      done_q      <= '0;
      latched_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.step) begin
        sgn_prev_q <= cur_sign;
        out_sign_q <= out_sign_d;
        phase_q    <= phase_d;
        count_q    <= count_d;
        target_q   <= target_base;
        done_q     <= done_d;
        latched_q  <= latched_base;
      end
      if (cmd_i.step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.in_valid = in_valid_i;
  assign stat_o.is_event = is_event;
  assign stat_o.div_busy = div_busy;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_trigger_o = out_trigger_q;
  assign out_fired_o   = out_fired_q;
endmodule

`default_nettype wire

// File: sv/beat_repeat_trigger_timer.sv
// Top level of the beat repeat trigger timer: register port, controller and datapath.
`default_nettype none

// One trigger sample is taken per request and gives one result. A sample
// without a trigger event goes from acceptance through evaluation to the
// result step, which waits for a free output register. A sample with a
// trigger event computes a new firing interval through a bit-serial divider
// that produces one quotient bit per cycle, NUM_W bits in all, where NUM_W =
// clog2((SAMPLE_RATE >> TICK_SHIFT) * 240 + 1) + 15, 34 at the defaults.
// Only one sample is in work at a time; the next request is taken as soon as
// the previous result sits in the output register, even while that result is
// still waiting to be taken. Registers are written through the APB port at
// byte addresses 0, 4, 8 and 12 (tempo, beat count, beat division, repeat
// limit) and are sampled only when a trigger event is processed.
module beat_repeat_trigger_timer #(
  parameter int unsigned TICK_SHIFT  = 5,
  parameter int unsigned SAMPLE_RATE = 48000,
  parameter int unsigned COUNT_WIDTH = 34
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  brt_in_if.sink           in_i,
  brt_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import brt_pkg::*;

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  logic  wr_en;
  logic [1:0] reg_idx;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tempo    <= TEMPO_RST;
      cfg_q.beats    <= BEATS_RST;
      cfg_q.division <= DIVISION_RST;
      cfg_q.repeats  <= REPEAT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TEMPO:    cfg_q.tempo    <= pwdata[CFG_W-1:0];
        REG_BEATS:    cfg_q.beats    <= pwdata[CFG_W-1:0];
        REG_DIVISION: cfg_q.division <= pwdata[CFG_W-1:0];
        REG_REPEAT:   cfg_q.repeats  <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TEMPO:    prdata = 32'(cfg_q.tempo);
      REG_BEATS:    prdata = 32'(cfg_q.beats);
      REG_DIVISION: prdata = 32'(cfg_q.division);
      REG_REPEAT:   prdata = 32'(cfg_q.repeats);
      default:      prdata = '0;
    endcase
  end

  brt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  brt_datapath #(
    .TICK_SHIFT  (TICK_SHIFT),
    .SAMPLE_RATE (SAMPLE_RATE),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_i.valid),
    .in_trigger_i     (in_i.trig_sample),
    .in_block_start_i (in_i.block_start),
    .out_ready_i      (out_o.ready),
    .stat_o           (stat),
    .out_valid_o      (out_o.valid),
    .out_trigger_o    (out_o.trigger_out),
    .out_fired_o      (out_o.fired)
  );

  assign in_i.ready = in_ready;
endmodule

`default_nettype wire

// File: sv/brt_checker.sv
// Port-level checker of the beat repeat trigger timer and its bind.
`default_nettype none

module brt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] trigger_out,
  input wire logic        fired
);
  // The result level is always silent or one of the two full-scale values.
  a_level_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (trigger_out == 16'h0000) || (trigger_out == 16'h7FFF) ||
                  (trigger_out == 16'h8001))
    else $error("illegal trigger level");

  // A firing always leaves a nonzero level.
  a_fired_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && fired) |-> (trigger_out != 16'h0000))
    else $error("fired with a silent level");

  // The block works on one request at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in work");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(trigger_out) && $stable(fired)))
    else $error("stalled result changed");
endmodule

bind beat_repeat_trigger_timer brt_checker u_brt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .trigger_out (out_o.trigger_out),
  .fired       (out_o.fired)
);

`default_nettype wire
